// ===== rtl/hkfsd_pkg.sv =====
`default_nettype none

package hkfsd_pkg;

    // character buffer geometry
    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);

    // frame header bytes
    localparam logic [7:0] HDR_SYNC0 = 8'h57;
    localparam logic [7:0] HDR_SYNC1 = 8'hAB;
    localparam logic [7:0] HDR_KEY   = 8'h88;
    localparam logic [7:0] HDR_RST   = 8'h82;

    // frame byte offsets
    localparam logic [7:0] POS_SYNC0  = 8'd0;
    localparam logic [7:0] POS_SYNC1  = 8'd1;
    localparam logic [7:0] POS_TYPE   = 8'd2;
    localparam logic [7:0] POS_LEN    = 8'd3;
    localparam logic [7:0] POS_SUM0   = 8'd5;
    localparam logic [7:0] POS_KEY    = 8'd7;
    localparam logic [7:0] POS_MINKEY = 8'd8;
    localparam logic [7:0] POS_MAX    = 8'd255;

    localparam logic [7:0]  KEY_NONE      = 8'hFF;
    localparam logic [15:0] SILENCE_RESET = 16'd100;

    // item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_RST  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic [6:0] ascii_char;
        logic       last;
    } t_result;

    // per-byte verdict from the frame checker
    typedef struct packed {
        logic       rst_req;
        logic       key_ok;
        logic [6:0] ascii;
    } t_frame_evt;

    // hid usage to ascii, zero when the code is not kept
    function automatic logic [6:0] key_to_ascii(input logic [7:0] code);
        logic [7:0] sum;
        sum = 8'h00;
        if (code inside {[8'h04:8'h1D]}) begin
            sum = code + 8'h3D;
        end else if (code inside {[8'h1E:8'h26]}) begin
            sum = code + 8'h13;
        end else if (code == 8'h27) begin
            sum = 8'h30;
        end else if (code == 8'h2C) begin
            sum = 8'h20;
        end
        return sum[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hkfsd_char_mem.sv =====
`default_nettype none

module hkfsd_char_mem (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire  [hkfsd_pkg::BUF_AW-1:0]    i_waddr,
    input  wire  [6:0]                      i_wdata,
    input  wire  [hkfsd_pkg::BUF_AW-1:0]    i_raddr,
    output logic [6:0]                      o_rdata
);

    logic [6:0] mem [hkfsd_pkg::BUF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/hkfsd_frame_chk.sv =====
`default_nettype none

module hkfsd_frame_chk (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_byte_vld,
    input  wire  [7:0]                  i_byte,
    input  wire                         i_frame_end,
    output hkfsd_pkg::t_frame_evt       o_evt
);

    logic [7:0] r_pos,  n_pos;
    logic       r_hdr_good, n_hdr_good;
    logic       r_rst_hdr,  n_rst_hdr;
    logic [7:0] r_sum_cnt,  n_sum_cnt;
    logic [7:0] r_sum,      n_sum;
    logic [7:0] r_key,      n_key;
    logic       r_sum_ok,   n_sum_ok;
    logic [7:0] rel;

    assign rel = r_pos - hkfsd_pkg::POS_SUM0;

    // fold the current byte into the frame state
    always_comb begin
        n_pos      = r_pos;
        n_hdr_good = r_hdr_good;
        n_rst_hdr  = r_rst_hdr;
        n_sum_cnt  = r_sum_cnt;
        n_sum      = r_sum;
        n_key      = r_key;
        n_sum_ok   = r_sum_ok;
        if (r_pos != hkfsd_pkg::POS_MAX) begin
            if (r_pos == hkfsd_pkg::POS_SYNC0) begin
                n_hdr_good = r_hdr_good && (i_byte == hkfsd_pkg::HDR_SYNC0);
                n_rst_hdr  = r_rst_hdr  && (i_byte == hkfsd_pkg::HDR_SYNC0);
            end else if (r_pos == hkfsd_pkg::POS_SYNC1) begin
                n_hdr_good = r_hdr_good && (i_byte == hkfsd_pkg::HDR_SYNC1);
                n_rst_hdr  = r_rst_hdr  && (i_byte == hkfsd_pkg::HDR_SYNC1);
            end else if (r_pos == hkfsd_pkg::POS_TYPE) begin
                n_hdr_good = r_hdr_good && (i_byte == hkfsd_pkg::HDR_KEY);
                n_rst_hdr  = r_rst_hdr  && (i_byte == hkfsd_pkg::HDR_RST);
            end else if (r_pos == hkfsd_pkg::POS_LEN) begin
                n_sum_cnt = i_byte - 8'd2;
            end else if (r_pos >= hkfsd_pkg::POS_SUM0) begin
                if (rel < r_sum_cnt) begin
                    n_sum = r_sum + i_byte;
                end else if (rel == r_sum_cnt) begin
                    n_sum_ok = (i_byte == r_sum);
                end
                if (r_pos == hkfsd_pkg::POS_KEY) begin
                    n_key = i_byte;
                end
            end
            n_pos = r_pos + 8'd1;
        end
    end

    assign o_evt.rst_req = (n_pos >= hkfsd_pkg::POS_LEN) && n_rst_hdr;
    assign o_evt.key_ok  = (n_pos >= hkfsd_pkg::POS_MINKEY) && n_hdr_good && n_sum_ok;
    assign o_evt.ascii   = hkfsd_pkg::key_to_ascii(n_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_byte_vld && i_frame_end)) begin
            r_pos      <= '0;
            r_hdr_good <= 1'b1;
            r_rst_hdr  <= 1'b1;
            r_sum_cnt  <= '0;
            r_sum      <= '0;
            r_key      <= hkfsd_pkg::KEY_NONE;
            r_sum_ok   <= 1'b0;
        end else if (i_byte_vld) begin
            r_pos      <= n_pos;
            r_hdr_good <= n_hdr_good;
            r_rst_hdr  <= n_rst_hdr;
            r_sum_cnt  <= n_sum_cnt;
            r_sum      <= n_sum;
            r_key      <= n_key;
            r_sum_ok   <= n_sum_ok;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hid_key_frame_scan_decoder_core.sv =====
`default_nettype none

// Key-report frame decoder. Each item is one serial byte of a bridge frame
// (func 0) or one time tick (func 1), taken when start is high and busy is
// low. Byte items and ticks that release nothing never raise busy. A frame
// with header 57 AB 88 and a good checksum adds the ASCII form of its mapped
// keycode, if the buffer has room, to a 32-entry character memory; a 57 AB 82
// frame gives one reset-request result in the cycle after its last byte.
// A tick that finds frames pending and silence_ticks of quiet releases the
// buffered string: busy then stays high while the buffered characters (up to
// 32) are read out, and the results come back to back, through r_emit and
// then the memory read register, the last one marked. The run's length is set
// by the single read port of the character memory, one entry a cycle.
// Results appear on o_res for one cycle under o_res_valid; the receiver
// cannot hold them off. The memory needs no clearing pass after reset.
module hid_key_frame_scan_decoder_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire hkfsd_pkg::t_item   i_item,
    input  wire                     i_cfg_we,
    input  wire  [15:0]             i_cfg_data,
    output logic                    o_res_valid,
    output hkfsd_pkg::t_result      o_res
);

    // accepted item
    logic acc;
    logic byte_acc;
    logic tick_acc;

    // silence register and release timer
    logic [15:0] r_silence;
    logic [15:0] r_quiet;
    logic [15:0] quiet_inc;
    logic        r_pending;
    logic        release_now;

    // character buffer bookkeeping
    logic [hkfsd_pkg::BUF_CW-1:0] r_char_cnt;
    logic                          buf_full;
    logic                          mem_we;
    logic [hkfsd_pkg::BUF_AW-1:0]  mem_waddr;
    logic [6:0]                    mem_rdata;

    // string emission walk
    logic                          r_emit;
    logic [hkfsd_pkg::BUF_AW-1:0]  r_rd_idx;
    logic [hkfsd_pkg::BUF_AW-1:0]  r_last_idx;
    logic                          rd_last;
    logic                          r_rd_vld;
    logic                          r_rd_last;
    logic                          r_rst_vld;

    hkfsd_pkg::t_frame_evt evt;

    assign busy     = r_emit;
    assign acc      = start && !busy;
    assign byte_acc = acc && (i_item.func == hkfsd_pkg::FUNC_BYTE);
    assign tick_acc = acc && (i_item.func == hkfsd_pkg::FUNC_TICK);

    hkfsd_frame_chk u_frame_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_vld  (byte_acc),
        .i_byte      (i_item.rx_byte),
        .i_frame_end (i_item.frame_end),
        .o_evt       (evt)
    );

    // a finished key frame with a mapped key appends one character unless the buffer is full
    assign buf_full  = (r_char_cnt >= hkfsd_pkg::BUF_CW'(hkfsd_pkg::BUF_DEPTH));
    assign mem_we    = byte_acc && i_item.frame_end && !evt.rst_req && evt.key_ok
                       && (evt.ascii != 7'd0) && !buf_full;
    assign mem_waddr = r_char_cnt[hkfsd_pkg::BUF_AW-1:0];

    // reads only run while busy, so writes and reads never meet on an entry
    hkfsd_char_mem u_char_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (evt.ascii),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    assign quiet_inc   = (r_quiet == 16'hFFFF) ? r_quiet : r_quiet + 16'd1;
    assign release_now = tick_acc && r_pending && (quiet_inc >= r_silence);
    assign rd_last     = (r_rd_idx == r_last_idx);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence <= hkfsd_pkg::SILENCE_RESET;
        end else if (i_cfg_we) begin
            r_silence <= i_cfg_data;
        end
    end

    // pending flag, quiet timer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b0;
            r_quiet    <= '0;
            r_char_cnt <= '0;
        end else if (tick_acc) begin
            if (release_now) begin
                r_pending  <= 1'b0;
                r_quiet    <= '0;
                r_char_cnt <= '0;
            end else begin
                r_quiet <= quiet_inc;
            end
        end else if (byte_acc && i_item.frame_end && !evt.rst_req) begin
            // any frame but a reset request restarts the silence timer
            r_pending <= 1'b1;
            r_quiet   <= '0;
            if (mem_we) begin
                r_char_cnt <= r_char_cnt + hkfsd_pkg::BUF_CW'(1);
            end
        end
    end

    // emission walk over the character memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit    <= 1'b0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_vld  <= r_emit;
            r_rd_last <= r_emit && rd_last;
            if (release_now && (r_char_cnt != '0)) begin
                r_emit   <= 1'b1;
                r_rd_idx <= '0;
            end else if (r_emit) begin
                if (rd_last) begin
                    r_emit <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + hkfsd_pkg::BUF_AW'(1);
                end
            end
        end
    end

    // index of the final character, captured at release
    always_ff @(posedge i_clk) begin
        if (release_now) begin
            r_last_idx <= hkfsd_pkg::BUF_AW'(r_char_cnt - hkfsd_pkg::BUF_CW'(1));
        end
    end

    // reset request result, in the cycle after the frame's last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_vld <= 1'b0;
        end else begin
            r_rst_vld <= byte_acc && i_item.frame_end && evt.rst_req;
        end
    end

    // read data is already registered in the memory, so it feeds the port
    assign o_res_valid = r_rd_vld || r_rst_vld;
    always_comb begin
        if (r_rd_vld) begin
            o_res.kind       = hkfsd_pkg::KIND_CHAR;
            o_res.ascii_char = mem_rdata;
            o_res.last       = r_rd_last;
        end else begin
            o_res.kind       = hkfsd_pkg::KIND_RST;
            o_res.ascii_char = 7'd0;
            o_res.last       = 1'b1;
        end
    end

    // a reset request never lands on a string result
    a_no_result_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rst_vld && r_rd_vld))
        else $error("reset result collides with string result");

    // fill count never passes the buffer depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_cnt <= hkfsd_pkg::BUF_CW'(hkfsd_pkg::BUF_DEPTH))
        else $error("character count overflow");

    // no character is stored while the buffer is being read out
    a_no_write_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> !mem_we)
        else $error("buffer written during emission");

    // the marked result ends the run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && r_rd_last) |=> !r_rd_vld)
        else $error("string result after last");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    import hkfsd_pkg::*;

    // hid usage codes the tests use; enter is not mapped by the decoder
    localparam logic [7:0] KEY_A     = 8'h04;
    localparam logic [7:0] KEY_Z     = 8'h1D;
    localparam logic [7:0] KEY_1     = 8'h1E;
    localparam logic [7:0] KEY_9     = 8'h26;
    localparam logic [7:0] KEY_0     = 8'h27;
    localparam logic [7:0] KEY_ENTER = 8'h28;
    localparam logic [7:0] KEY_SPACE = 8'h2C;

    // length byte 5 gives three summed bytes (offsets 5..7), checksum at 8
    localparam logic [7:0] LEN_STD = 8'd5;

    // settle wait long enough for a full string release
    localparam int SETTLE_CYCLES = BUF_DEPTH + 8;
    localparam int RAND_ITEMS    = 150;

    typedef enum logic [1:0] {
        STEP_FRAME,
        STEP_TICKS,
        STEP_SILENCE,
        STEP_FILL
    } t_step_op;

    // one row of the directed plan
    typedef struct {
        t_step_op    op;
        logic [7:0]  kind_byte;
        logic [7:0]  len;
        logic [7:0]  key;
        bit          bad_sum;
        int          nbytes;    // 0: natural frame length
        int          count;     // ticks or frames
        logic [15:0] value;     // silence setting
        bit          typed;     // expected results given in the row
        string       text;      // released string for typed tick rows
    } t_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        o_res_valid;
    t_result     o_res;

    hid_key_frame_scan_decoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // decoder state as the testbench sees it
    logic [15:0] silence;
    logic [7:0]  frame_pos;
    logic        hdr_key_ok;
    logic        hdr_rst_ok;
    logic [7:0]  sum_len;
    logic [7:0]  sum_acc;
    logic [7:0]  key_code;
    logic        sum_ok;
    logic        pending;
    logic [15:0] quiet;
    logic [6:0]  char_buf[$];

    t_result due_results[$];
    t_result no_results[$];
    t_result head;
    int      mismatches = 0;
    int      items_taken = 0;
    bit      gaps_on = 1'b1;

    // directed plan: extremes, every mapped key group, each odd frame shape
    t_step plan [29] = '{
        // reset value of silence: 100 ticks release the string
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_A,     0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_Z,     0, 0,   0,   0, 0, ""},
        '{STEP_TICKS,   8'h00,   8'h00,   8'h00,     0, 0,   100, 0, 1, "AZ"},
        // zero silence: first tick releases
        '{STEP_SILENCE, 8'h00,   8'h00,   8'h00,     0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_1,     0, 0,   0,   0, 0, ""},
        '{STEP_TICKS,   8'h00,   8'h00,   8'h00,     0, 0,   1,   0, 1, "1"},
        '{STEP_SILENCE, 8'h00,   8'h00,   8'h00,     0, 0,   0,   1, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_9,     0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_0,     0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_SPACE, 0, 0,   0,   0, 0, ""},
        // skipped codes: enter, none, all ones, just outside the mapped ranges
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_ENTER, 0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, 8'h00,     0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, 8'hFF,     0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, 8'h03,     0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, 8'h2D,     0, 0,   0,   0, 0, ""},
        // bridge reset request
        '{STEP_FRAME,   HDR_RST, LEN_STD, KEY_A,     0, 0,   0,   0, 1, ""},
        // bad header, bad checksum, short, cut before checksum
        '{STEP_FRAME,   8'h77,   LEN_STD, KEY_A,     0, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_A,     1, 0,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_A,     0, 2,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_A,     0, 8,   0,   0, 0, ""},
        // length below two wraps; long frame runs past the saturated position
        '{STEP_FRAME,   HDR_KEY, 8'd1,    KEY_A,     0, 9,   0,   0, 0, ""},
        '{STEP_FRAME,   HDR_KEY, 8'd0,    KEY_A,     0, 300, 0,   0, 0, ""},
        '{STEP_TICKS,   8'h00,   8'h00,   8'h00,     0, 0,   1,   0, 1, "90 "},
        // pending but nothing buffered: release gives no result
        '{STEP_FRAME,   HDR_KEY, LEN_STD, KEY_A,     1, 0,   0,   0, 0, ""},
        '{STEP_TICKS,   8'h00,   8'h00,   8'h00,     0, 0,   2,   0, 1, ""},
        // reset request with only the header
        '{STEP_FRAME,   HDR_RST, LEN_STD, KEY_A,     0, 3,   0,   0, 1, ""},
        // more characters than the buffer holds
        '{STEP_SILENCE, 8'h00,   8'h00,   8'h00,     0, 0,   0,   3, 0, ""},
        '{STEP_FILL,    8'h00,   8'h00,   8'h00,     0, 0,   34,  0, 0, ""},
        '{STEP_TICKS,   8'h00,   8'h00,   8'h00,     0, 0,   3,   0, 0, ""}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[hid_key_frame_scan_decoder_core] ERROR");
        $finish;
    end

    function automatic void clear_frame();
        frame_pos  = 8'd0;
        hdr_key_ok = 1'b1;
        hdr_rst_ok = 1'b1;
        sum_len    = 8'd0;
        sum_acc    = 8'd0;
        key_code   = KEY_NONE;
        sum_ok     = 1'b0;
    endfunction

    // work out the results one accepted item causes and advance the state
    function automatic void decode_item(input t_item it, output t_result res[$]);
        logic [7:0] b;
        logic [7:0] rel;
        logic [7:0] c;
        b = it.rx_byte;
        c = 8'h00;
        res.delete();
        if (it.func == FUNC_TICK) begin
            if (quiet != 16'hFFFF) quiet++;
            if (!pending || quiet < silence) return;
            foreach (char_buf[i])
                res.push_back('{KIND_CHAR, char_buf[i], 1'(i == char_buf.size() - 1)});
            pending = 1'b0;
            quiet   = 16'd0;
            char_buf.delete();
            return;
        end
        if (frame_pos != POS_MAX) begin
            case (frame_pos)
                POS_SYNC0: begin
                    hdr_key_ok &= (b == HDR_SYNC0);
                    hdr_rst_ok &= (b == HDR_SYNC0);
                end
                POS_SYNC1: begin
                    hdr_key_ok &= (b == HDR_SYNC1);
                    hdr_rst_ok &= (b == HDR_SYNC1);
                end
                POS_TYPE: begin
                    hdr_key_ok &= (b == HDR_KEY);
                    hdr_rst_ok &= (b == HDR_RST);
                end
                POS_LEN: begin
                    sum_len = b - 8'd2;
                end
                default: begin
                    if (frame_pos >= POS_SUM0) begin
                        rel = frame_pos - POS_SUM0;
                        if (rel < sum_len) sum_acc = sum_acc + b;
                        else if (rel == sum_len) sum_ok = (b == sum_acc);
                        if (frame_pos == POS_KEY) key_code = b;
                    end
                end
            endcase
            frame_pos++;
        end
        if (!it.frame_end) return;
        if (frame_pos >= 8'd3 && hdr_rst_ok) begin
            clear_frame();
            res.push_back('{KIND_RST, 7'd0, 1'b1});
            return;
        end
        pending = 1'b1;
        quiet   = 16'd0;
        if (frame_pos >= POS_MINKEY && hdr_key_ok && sum_ok) begin
            if (key_code >= KEY_A && key_code <= KEY_Z) c = "A" + (key_code - KEY_A);
            else if (key_code >= KEY_1 && key_code <= KEY_9) c = "1" + (key_code - KEY_1);
            else if (key_code == KEY_0) c = "0";
            else if (key_code == KEY_SPACE) c = " ";
            if (c != 8'h00 && char_buf.size() < BUF_DEPTH) char_buf.push_back(c[6:0]);
        end
        clear_frame();
    endfunction

    // offer one item, wait until taken, queue what it should produce
    task automatic send_item(input t_item it, input bit typed, input t_result fixed[$]);
        t_result res[$];
        int n;
        int r;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_taken++;
        decode_item(it, res);
        if (typed) res = fixed;
        foreach (res[i]) due_results.push_back(res[i]);
        // sender gap: mostly none or short, now and then long
        n = 0;
        if (gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 97) n = $urandom_range(20, 60);
            else if (r >= 85) n = $urandom_range(4, 12);
            else if (r >= 55) n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // build a frame byte by byte; the checksum follows the summed bytes
    task automatic send_frame(input logic [7:0] kind_byte, input logic [7:0] len,
                              input logic [7:0] key, input bit bad_sum,
                              input int nbytes, input bit rst_typed);
        logic [7:0] n_sum;
        logic [7:0] acc;
        logic [7:0] b;
        int total;
        bit tail;
        t_result fixed[$];
        n_sum = len - 8'd2;
        acc   = 8'd0;
        total = (nbytes > 0) ? nbytes : 6 + int'(n_sum);
        for (int p = 0; p < total; p++) begin
            if (p == 0) b = HDR_SYNC0;
            else if (p == 1) b = HDR_SYNC1;
            else if (p == 2) b = kind_byte;
            else if (p == 3) b = len;
            else if (p >= 5 && p < 5 + int'(n_sum)) begin
                b = (p == 7) ? key : 8'($urandom);
                acc = acc + b;
            end else if (p == 5 + int'(n_sum)) begin
                b = bad_sum ? (acc ^ (8'h01 << $urandom_range(0, 7))) : acc;
            end else begin
                b = 8'($urandom);
            end
            tail = (p == total - 1);
            fixed.delete();
            if (rst_typed && tail) fixed.push_back('{KIND_RST, 7'd0, 1'b1});
            send_item('{FUNC_BYTE, b, tail}, rst_typed && tail, fixed);
        end
    endtask

    // tick items carry random bytes in the fields a tick ignores
    task automatic send_ticks(input int count, input bit typed, input string text);
        t_result fixed[$];
        bit final_tick;
        for (int k = 0; k < count; k++) begin
            final_tick = (k == count - 1);
            fixed.delete();
            if (typed && final_tick) begin
                for (int i = 0; i < text.len(); i++)
                    fixed.push_back('{KIND_CHAR, 7'(text[i]), 1'(i == text.len() - 1)});
            end
            send_item('{FUNC_TICK, 8'($urandom), 1'($urandom)}, typed && final_tick, fixed);
        end
    endtask

    // register write only once the block has gone quiet
    task automatic write_silence(input logic [15:0] v);
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        silence = v;
    endtask

    // results cannot be held off: check each one in the cycle it shows
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, kind %0d char %02h last %0d",
                         $time, o_res.kind, o_res.ascii_char, o_res.last);
                mismatches++;
            end else begin
                head = due_results.pop_front();
                if (o_res.kind !== head.kind) begin
                    $display("%0t: kind expected %0d got %0d", $time, head.kind, o_res.kind);
                    mismatches++;
                end
                if (o_res.ascii_char !== head.ascii_char) begin
                    $display("%0t: ascii_char expected %02h got %02h",
                             $time, head.ascii_char, o_res.ascii_char);
                    mismatches++;
                end
                if (o_res.last !== head.last) begin
                    $display("%0t: last expected %0d got %0d", $time, head.last, o_res.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int base_items;
        int r;
        int sub;
        logic [7:0] key;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        silence = SILENCE_RESET;
        pending = 1'b0;
        quiet   = 16'd0;
        char_buf.delete();
        clear_frame();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan
        foreach (plan[i]) begin
            case (plan[i].op)
                STEP_FRAME: send_frame(plan[i].kind_byte, plan[i].len, plan[i].key,
                                       plan[i].bad_sum, plan[i].nbytes, plan[i].typed);
                STEP_TICKS: send_ticks(plan[i].count, plan[i].typed, plan[i].text);
                STEP_SILENCE: write_silence(plan[i].value);
                STEP_FILL: begin
                    repeat (plan[i].count)
                        send_frame(HDR_KEY, LEN_STD, 8'($urandom_range(KEY_A, KEY_0)),
                                   1'b0, 0, 1'b0);
                end
                default: ;
            endcase
        end

        // random part: mostly well-formed frames, some noise and broken ones
        base_items = items_taken;
        while (items_taken - base_items < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                sub = $urandom_range(0, 3);
                write_silence((sub == 0) ? 16'd0 : (sub == 1) ? 16'd1
                                                              : 16'($urandom_range(2, 12)));
                gaps_on = ($urandom_range(0, 3) != 0);
            end else if (r < 55) begin
                if ($urandom_range(0, 99) < 85) begin
                    key = ($urandom_range(0, 9) == 0) ? KEY_SPACE
                                                      : 8'($urandom_range(KEY_A, KEY_0));
                end else begin
                    key = 8'($urandom);
                end
                send_frame(HDR_KEY, 8'($urandom_range(4, 8)), key, 1'b0, 0, 1'b0);
            end else if (r < 63) begin
                send_frame(HDR_RST, 8'($urandom), 8'($urandom), 1'b0,
                           $urandom_range(3, 10), 1'b0);
            end else if (r < 73) begin
                sub = $urandom_range(0, 2);
                if (sub == 0)
                    send_frame(8'($urandom), LEN_STD, KEY_A, 1'b0, 0, 1'b0);
                else if (sub == 1)
                    send_frame(HDR_KEY, LEN_STD, 8'($urandom), 1'b1, 0, 1'b0);
                else
                    send_frame(HDR_KEY, LEN_STD, KEY_A, 1'b0, $urandom_range(1, 8), 1'b0);
            end else if (r < 78) begin
                // loose bytes, possibly leaving a frame open
                repeat ($urandom_range(1, 5))
                    send_item('{FUNC_BYTE, 8'($urandom), 1'($urandom)}, 1'b0, no_results);
            end else begin
                send_ticks($urandom_range(1, int'(silence) + 2), 1'b0, "");
            end
        end

        // top silence setting: a few ticks after a frame release nothing
        write_silence(16'hFFFF);
        gaps_on = 1'b1;
        send_frame(HDR_KEY, LEN_STD, KEY_Z, 1'b0, 0, 1'b0);
        send_ticks(8, 1'b0, "");

        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[hid_key_frame_scan_decoder_core] OK");
        end else begin
            $display("[hid_key_frame_scan_decoder_core] ERROR");
        end
        $finish;
    end

endmodule
